/* rtl/scpq_pkg.sv */
// Package for the staged/completed packet queue: word types, action codes and sizes.
// No dependencies.
package scpq_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = 4;
  localparam int PTR_W      = 5;
  localparam int CNT_W      = 5;
  localparam int KEY_W      = 16;

  localparam logic [2:0] ACT_ENQUEUE   = 3'd0;
  localparam logic [2:0] ACT_FIND_STG  = 3'd1;
  localparam logic [2:0] ACT_MARK      = 3'd2;
  localparam logic [2:0] ACT_FIND_CMP  = 3'd3;
  localparam logic [2:0] ACT_REMOVE    = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] packet_handle;
    logic [1:0]  addr_mode;
    logic [63:0] addr_value;
    logic [3:0]  entry_index;
    logic [3:0]  prev_index;
    logic        prev_none;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  found_index;
    logic [3:0]  found_prev_index;
    logic        found_prev_none;
    logic [1:0]  stored_addr_mode;
    logic [63:0] stored_addr_value;
    logic [4:0]  free_count;
    logic [4:0]  queued_count;
  } out_word_t;

  // Memory port request from the list controller to the entry store.
  typedef struct packed {
    logic        rd;
    logic [3:0]  rd_idx;
    logic        lwr;
    logic [3:0]  lwr_idx;
    logic [4:0]  lwr_data;
    logic        dwr;
    logic [3:0]  dwr_idx;
  } mem_req_t;

endpackage

/* rtl/scpq_store.sv */
// Entry store of the packet queue: link memory plus handle and address memories.
// Depends on scpq_pkg.
module scpq_store import scpq_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mem_req_t               req,
  input  logic [HANDLE_BITS-1:0] wr_handle,
  input  logic [1:0]             wr_mode,
  input  logic [63:0]            wr_addr,
  output logic [PTR_W-1:0]       rd_link,
  output logic [HANDLE_BITS-1:0] rd_handle,
  output logic [1:0]             rd_mode,
  output logic [63:0]            rd_addr,
  output logic                   init_done
);

  logic [PTR_W-1:0]       link_mem [POOL_DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [POOL_DEPTH];
  logic [1:0]             mode_mem [POOL_DEPTH];
  logic [63:0]            addr_mem [POOL_DEPTH];
  logic [PTR_W-1:0]       init_ptr;

  // After reset a pass writes the initial free chain, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_ptr  <= '0;
      init_done <= 1'b0;
    end else if (!init_done) begin
      init_ptr <= init_ptr + 1'b1;
      if (init_ptr == PTR_W'(POOL_DEPTH - 1)) init_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done) begin
      link_mem[init_ptr[IDX_W-1:0]] <= (init_ptr == '0) ? PTR_W'(POOL_DEPTH)
                                                         : init_ptr - 1'b1;
    end else if (req.lwr) begin
      link_mem[req.lwr_idx] <= req.lwr_data;
    end
    if (req.rd) rd_link <= link_mem[req.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (req.dwr) begin
      handle_mem[req.dwr_idx] <= wr_handle;
      mode_mem[req.dwr_idx]   <= wr_mode;
      addr_mem[req.dwr_idx]   <= wr_addr;
    end
    if (req.rd) begin
      rd_handle <= handle_mem[req.rd_idx];
      rd_mode   <= mode_mem[req.rd_idx];
      rd_addr   <= addr_mem[req.rd_idx];
    end
  end

endmodule

/* rtl/scpq_ctrl.sv */
// List controller: walks and relinks the free, staged and completed lists.
// Depends on scpq_pkg.
module scpq_ctrl import scpq_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   init_done,
  input  in_word_t               in_word,
  input  logic                   in_take,
  output logic                   busy,
  output mem_req_t               req,
  output logic [HANDLE_BITS-1:0] wr_handle,
  output logic [1:0]             wr_mode,
  output logic [63:0]            wr_addr,
  input  logic [PTR_W-1:0]       rd_link,
  input  logic [HANDLE_BITS-1:0] rd_handle,
  input  logic [1:0]             rd_mode,
  input  logic [63:0]            rd_addr,
  output logic                   res_valid,
  output out_word_t              res_word,
  input  logic                   res_ready
);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state, state_next;
  in_word_t               cmd;
  logic [PTR_W-1:0]       free_head, stg_head, stg_tail, cmp_head, cmp_tail;
  logic [CNT_W-1:0]       free_total, queued_total;
  logic [PTR_W-1:0]       cur, pred, nxt;
  logic [PTR_W:0]         steps;
  logic                   ok;
  logic [3:0]             idx;
  logic [PTR_W-1:0]       rpred;
  logic [1:0]             smode;
  logic [63:0]            saddr;
  logic [HANDLE_BITS-1:0] key;
  logic                   fix_step;

  function automatic logic valid_ptr(input logic [PTR_W-1:0] p);
    return p < NIL;
  endfunction

  assign key       = HANDLE_BITS'(cmd.packet_handle);
  assign wr_handle = key;
  assign wr_mode   = cmd.addr_mode;
  assign wr_addr   = cmd.addr_value;
  assign busy      = (state != S_IDLE) || !init_done;

  logic walk_hit;
  always_comb begin
    if (cmd.action == ACT_MARK) walk_hit = (cur[IDX_W-1:0] == cmd.entry_index);
    else                        walk_hit = (rd_handle == key);
  end

  // Memory requests are made combinationally from the registered state.
  always_comb begin
    req = '0;
    unique case (state)
      S_WALK: begin
        req.rd     = 1'b1;
        req.rd_idx = cur[IDX_W-1:0];
      end
      S_DATA: begin
        req.rd     = 1'b1;
        req.rd_idx = idx;
        // Enqueue hangs the new entry on the old staged tail; mark ends the
        // moved entry's chain.
        if (cmd.action == ACT_ENQUEUE) begin
          req.lwr      = valid_ptr(rpred);
          req.lwr_idx  = rpred[IDX_W-1:0];
          req.lwr_data = {1'b0, idx};
        end else if (cmd.action == ACT_MARK) begin
          req.lwr      = 1'b1;
          req.lwr_idx  = idx;
          req.lwr_data = NIL;
        end
      end
      S_FIX: begin
        // The completed-tail write is suppressed when the list was empty.
        if (fix_step == 1'b0) begin
          req.lwr      = ok && valid_ptr(rpred);
          req.lwr_idx  = rpred[IDX_W-1:0];
          req.lwr_data = nxt;
        end else begin
          req.lwr      = valid_ptr(cmp_head);
          req.lwr_idx  = cmp_tail[IDX_W-1:0];
          req.lwr_data = {1'b0, idx};
        end
      end
      default: ;
    endcase
    if (state == S_IDLE && in_take) begin
      req.rd     = 1'b1;
      req.rd_idx = (in_word.action == ACT_REMOVE) ? cmp_head[IDX_W-1:0]
                                                  : free_head[IDX_W-1:0];
    end
    // Enqueue and remove writes happen once the head's link is back.
    if (state == S_LINK) begin
      req.lwr = 1'b1;
      req.lwr_idx = idx;
      if (cmd.action == ACT_ENQUEUE) begin
        req.lwr_data = NIL;
        req.dwr      = 1'b1;
        req.dwr_idx  = idx;
      end else begin
        req.lwr_data = free_head;
      end
    end
  end

  // Walk tracking: a lookup issued in one cycle returns the next.
  logic walk_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= NIL - 1'b1;
      stg_head     <= NIL;
      stg_tail     <= NIL;
      cmp_head     <= NIL;
      cmp_tail     <= NIL;
      free_total   <= CNT_W'(POOL_DEPTH);
      queued_total <= '0;
      res_valid    <= 1'b0;
      walk_wait    <= 1'b0;
      fix_step     <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            cmd       <= in_word;
            ok        <= 1'b0;
            rpred     <= NIL;
            walk_wait <= 1'b0;
            steps     <= '0;
            pred      <= NIL;
            fix_step  <= 1'b0;
            if (in_word.action == ACT_ENQUEUE) begin
              idx <= free_head[IDX_W-1:0];
            end else if (in_word.action == ACT_REMOVE) begin
              idx <= cmp_head[IDX_W-1:0];
            end else begin
              idx <= '0;
              cur <= (in_word.action == ACT_FIND_CMP) ? cmp_head : stg_head;
            end
          end
        end
        S_LINK: begin
          ok <= 1'b1;
          if (cmd.action == ACT_ENQUEUE) begin
            free_head <= rd_link;
            rpred     <= stg_tail;
            if (!valid_ptr(stg_head)) stg_head <= {1'b0, idx};
            stg_tail     <= {1'b0, idx};
            free_total   <= free_total - 1'b1;
            queued_total <= queued_total + 1'b1;
          end else begin
            cmp_head <= rd_link;
            if (cmp_tail == {1'b0, idx}) cmp_tail <= NIL;
            free_head    <= {1'b0, idx};
            free_total   <= free_total + 1'b1;
            queued_total <= queued_total - 1'b1;
          end
        end
        S_WALK: begin
          if (!walk_wait) begin
            walk_wait <= 1'b1;
          end else begin
            walk_wait <= 1'b0;
            steps     <= steps + 1'b1;
            if (walk_hit) begin
              idx   <= cur[IDX_W-1:0];
              rpred <= pred;
              nxt   <= rd_link;
              if (cmd.action == ACT_MARK) begin
                ok <= cmd.prev_none ? !valid_ptr(pred)
                                    : (valid_ptr(pred) &&
                                       pred[IDX_W-1:0] == cmd.prev_index);
              end else begin
                ok <= 1'b1;
              end
            end else begin
              pred <= cur;
              cur  <= rd_link;
            end
          end
        end
        S_FIX: begin
          // First unlink from staged, then hang on the completed tail.
          if (fix_step == 1'b0) begin
            fix_step <= 1'b1;
            if (ok) begin
              if (!valid_ptr(rpred)) stg_head <= nxt;
              if (stg_tail == {1'b0, idx}) stg_tail <= rpred;
            end
          end else begin
            if (!valid_ptr(cmp_head)) cmp_head <= {1'b0, idx};
            cmp_tail <= {1'b0, idx};
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic walk_end;
  assign walk_end = walk_wait && (walk_hit ||
                    !valid_ptr(rd_link) || steps == (PTR_W + 1)'(POOL_DEPTH - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_word.action == ACT_ENQUEUE)
            state_next = valid_ptr(free_head) ? S_LINK : S_DONE;
          else if (in_word.action == ACT_REMOVE)
            state_next = valid_ptr(cmp_head) ? S_LINK : S_DONE;
          else if (in_word.action == ACT_FIND_STG || in_word.action == ACT_MARK)
            state_next = valid_ptr(stg_head) ? S_WALK : S_DONE;
          else if (in_word.action == ACT_FIND_CMP)
            state_next = valid_ptr(cmp_head) ? S_WALK : S_DONE;
          else
            state_next = S_DONE;
        end
      end
      S_LINK: state_next = S_DATA;
      S_WALK: begin
        if (walk_end) begin
          if (walk_hit && cmd.action == ACT_MARK) state_next = S_FIX;
          else if (walk_hit) state_next = S_DATA;
          else state_next = S_DONE;
        end
      end
      S_FIX: begin
        if (fix_step == 1'b0) begin
          if (!ok) state_next = S_DONE;
        end else begin
          state_next = S_DATA;
        end
      end
      S_DATA: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Data read in S_DATA returns in S_DONE.
  always_comb begin
    smode = rd_mode;
    saddr = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      res_word.ok               <= ok;
      res_word.found_index      <= ok ? idx : '0;
      res_word.found_prev_index <= (ok && valid_ptr(rpred)) ? rpred[IDX_W-1:0] : '0;
      res_word.found_prev_none  <= ok && !valid_ptr(rpred);
      res_word.stored_addr_mode  <= ok ? smode : '0;
      res_word.stored_addr_value <= ok ? saddr : '0;
      res_word.free_count       <= free_total;
      res_word.queued_count     <= queued_total;
    end
  end

endmodule

/* rtl/staged_completed_packet_queue.sv */
// Staged/completed packet queue over a pool of POOL_DEPTH entries held in synchronous
// memories. One word is processed at a time. Each step of a find or mark walk waits for
// its memory read, and a walk visits at most POOL_DEPTH entries; an empty pool or list
// or an unknown action goes straight to the result. The next word is accepted in the
// cycle after the result is taken. After reset a pass builds the free list; no word
// is accepted until it ends.
// Depends on scpq_pkg, scpq_store and scpq_ctrl.
module staged_completed_packet_queue import scpq_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  mem_req_t               req;
  logic [HANDLE_BITS-1:0] wr_handle, rd_handle;
  logic [1:0]             wr_mode;
  logic [63:0]            wr_addr;
  logic [PTR_W-1:0]       rd_link;
  logic [1:0]             rd_mode;
  logic [63:0]            rd_addr;
  logic                   init_done, busy, take;

  assign in_ready = !busy && !out_valid;
  assign take     = in_valid && in_ready;

  scpq_ctrl #(.HANDLE_BITS(HANDLE_BITS)) u_ctrl (
    .clk, .rst, .init_done,
    .in_word(in_data), .in_take(take), .busy,
    .req, .wr_handle, .wr_mode, .wr_addr,
    .rd_link, .rd_handle, .rd_mode, .rd_addr,
    .res_valid(out_valid), .res_word(out_data), .res_ready(out_ready)
  );

  scpq_store #(.HANDLE_BITS(HANDLE_BITS)) u_store (
    .clk, .rst, .req,
    .wr_handle, .wr_mode, .wr_addr,
    .rd_link, .rd_handle, .rd_mode, .rd_addr, .init_done
  );

endmodule

/* verif/testbench.sv */
// Testbench for staged_completed_packet_queue: directed table plus random list traffic,
// checked against a behavioral model of the three linked lists.
// Depends on scpq_pkg and the RTL of staged_completed_packet_queue.
`timescale 1ns / 1ps

module testbench;
  import scpq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int NIL       = 16;
  localparam int N_RANDOM  = 1930;
  localparam int CYCLE_CAP = 400000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  staged_completed_packet_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the pool.
  int          nxt [DEPTH];
  logic [15:0] hnd [DEPTH];
  logic [1:0]  amode [DEPTH];
  logic [63:0] aval [DEPTH];
  int          free_hd, stg_hd, stg_tl, cmp_hd, cmp_tl, n_free, n_queued;

  out_word_t pending_results [$];
  int        mismatches;
  int        cycle_count;
  bit        timed_out;

  task automatic pool_reset();
    for (int i = 0; i < DEPTH; i++) begin
      nxt[i] = (i == 0) ? NIL : i - 1;
      hnd[i] = '0; amode[i] = '0; aval[i] = '0;
    end
    free_hd = DEPTH - 1; stg_hd = NIL; stg_tl = NIL; cmp_hd = NIL; cmp_tl = NIL;
    n_free = DEPTH; n_queued = 0;
  endtask

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    bit ok;
    int idx, pred, cur, steps;
    ok = 0; idx = 0; pred = NIL;
    case (w.action)
      ACT_ENQUEUE: begin
        if (free_hd != NIL) begin
          idx = free_hd; free_hd = nxt[idx]; pred = stg_tl;
          if (stg_hd == NIL) stg_hd = idx;
          else nxt[stg_tl] = idx;
          stg_tl = idx; nxt[idx] = NIL;
          hnd[idx] = w.packet_handle; amode[idx] = w.addr_mode; aval[idx] = w.addr_value;
          n_free--; n_queued++; ok = 1;
        end
      end
      ACT_FIND_STG, ACT_FIND_CMP: begin
        cur = (w.action == ACT_FIND_STG) ? stg_hd : cmp_hd;
        for (steps = 0; steps < DEPTH && cur != NIL && !ok; steps++) begin
          if (hnd[cur] == w.packet_handle) begin
            idx = cur; ok = 1;
          end else begin
            pred = cur; cur = nxt[cur];
          end
        end
        if (!ok) pred = NIL;
      end
      ACT_MARK: begin
        cur = stg_hd;
        for (steps = 0; steps < DEPTH && cur != NIL && !ok; steps++) begin
          if (cur == int'(w.entry_index)) begin
            idx = cur; ok = 1;
          end else begin
            pred = cur; cur = nxt[cur];
          end
        end
        if (ok && !(w.prev_none ? pred == NIL : (pred != NIL && pred == int'(w.prev_index))))
          ok = 0;
        if (ok) begin
          if (pred == NIL) stg_hd = nxt[idx];
          else nxt[pred] = nxt[idx];
          if (stg_tl == idx) stg_tl = pred;
          nxt[idx] = NIL;
          if (cmp_hd == NIL) cmp_hd = idx;
          else nxt[cmp_tl] = idx;
          cmp_tl = idx;
        end
      end
      ACT_REMOVE: begin
        if (cmp_hd != NIL) begin
          idx = cmp_hd; cmp_hd = nxt[idx];
          if (cmp_tl == idx) cmp_tl = NIL;
          nxt[idx] = free_hd; free_hd = idx;
          n_free++; n_queued--; pred = NIL; ok = 1;
        end
      end
      default: ;
    endcase
    r = '0;
    if (ok) begin
      r.ok = 1'b1;
      r.found_index = idx[3:0];
      r.found_prev_index = (pred == NIL) ? 4'd0 : pred[3:0];
      r.found_prev_none = (pred == NIL);
      r.stored_addr_mode = amode[idx];
      r.stored_addr_value = aval[idx];
    end
    r.free_count = n_free[4:0];
    r.queued_count = n_queued[4:0];
    return r;
  endfunction

  // Sender: bursts of words with random gaps.
  int burst_left;

  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_word(w));
    burst_left--;
  endtask

  function automatic in_word_t make_word(logic [2:0] act, logic [15:0] h);
    in_word_t w;
    w.action = act; w.packet_handle = h;
    w.addr_mode = 2'($urandom_range(0, 3));
    w.addr_value = {$urandom, $urandom};
    w.entry_index = 4'($urandom_range(0, 15));
    w.prev_index = 4'($urandom_range(0, 15));
    w.prev_none = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Receiver stalls on its own phase pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %h, got %h", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP && !timed_out) begin
      timed_out = 1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    in_word_t  word;
    bit        has_expect;
    out_word_t expect_word;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic stim_row_t row(logic [2:0] act, logic [15:0] h, logic [1:0] am,
                                    logic [63:0] av, logic [3:0] ei, logic [3:0] pi,
                                    logic pn);
    stim_row_t s;
    s.word = '{act, h, am, av, ei, pi, pn};
    s.has_expect = 0;
    s.expect_word = '0;
    return s;
  endfunction

  initial begin
    stim_row_t s;
    in_word_t w;
    int staged [$];
    int pick, k;
    mismatches = 0; cycle_count = 0; timed_out = 0; burst_left = 0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    pool_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty-list cases right after reset have outcomes known by hand.
    s = row(ACT_REMOVE, 16'h0, 0, 0, 0, 0, 0);
    s.has_expect = 1; s.expect_word.free_count = 5'd16;
    directed.push_back(s);
    s = row(ACT_FIND_STG, 16'hffff, 0, 0, 0, 0, 0);
    s.has_expect = 1; s.expect_word.free_count = 5'd16;
    directed.push_back(s);
    s = row(ACT_ENQUEUE, 16'hffff, 2'd3, 64'hffff_ffff_ffff_ffff, 0, 0, 0);
    s.has_expect = 1;
    s.expect_word = '{1'b1, 4'd15, 4'd0, 1'b1, 2'd3, 64'hffff_ffff_ffff_ffff, 5'd15, 5'd1};
    directed.push_back(s);
    directed.push_back(row(ACT_ENQUEUE, 16'h0000, 2'd0, 64'h0, 0, 0, 0));
    directed.push_back(row(ACT_ENQUEUE, 16'h5a5a, 2'd1, 64'h5555_aaaa_0f0f_f0f0, 0, 0, 0));
    directed.push_back(row(ACT_FIND_STG, 16'h0000, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FIND_STG, 16'h1234, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_MARK, 0, 0, 0, 4'd14, 4'd15, 1'b1));
    directed.push_back(row(ACT_MARK, 0, 0, 0, 4'd14, 4'd15, 1'b0));
    directed.push_back(row(ACT_MARK, 0, 0, 0, 4'd13, 4'd15, 1'b0));
    directed.push_back(row(ACT_MARK, 0, 0, 0, 4'd0, 4'd0, 1'b0));
    directed.push_back(row(ACT_FIND_CMP, 16'h0000, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FIND_CMP, 16'h5a5a, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_MARK, 0, 0, 0, 4'd15, 4'd0, 1'b1));
    directed.push_back(row(ACT_REMOVE, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(3'd5, 16'h1, 0, 0, 0, 0, 0));
    directed.push_back(row(3'd7, 16'h1, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      directed.push_back(row(ACT_ENQUEUE, 16'(i * 3), 2'(i), {32'(i), 32'hdead_beef}, 0, 0, 0));

    foreach (directed[i]) begin
      send_word(directed[i].word);
      if (directed[i].has_expect && pending_results[$] !== directed[i].expect_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Row %0d: hand value %h, model %h", i, directed[i].expect_word,
                   pending_results[$]);
      end
    end

    // Random part: mostly legal marks and finds of live handles, some noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      w = make_word(3'($urandom_range(0, 4)), 16'($urandom_range(0, 15)));
      if ($urandom_range(0, 19) == 0) w.action = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) w.packet_handle = 16'($urandom);
      if (w.action == ACT_MARK && $urandom_range(0, 4) != 0) begin
        staged.delete();
        for (k = stg_hd; k != NIL; k = nxt[k]) staged.push_back(k);
        if (staged.size() != 0) begin
          pick = $urandom_range(0, staged.size() - 1);
          w.entry_index = 4'(staged[pick]);
          w.prev_none = (pick == 0);
          w.prev_index = (pick == 0) ? 4'($urandom_range(0, 15)) : 4'(staged[pick - 1]);
        end
      end
      send_word(w);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
